// ----- src/cpf_pkg.sv -----
// Shared types, constants and helper functions for the CPF check digit validator.
// Used by the channel interfaces and every module of the block; depends on nothing.
`default_nettype none

package cpf_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef logic [7:0] char_t;
  typedef logic [3:0] digit_t;
  typedef logic [3:0] count_t;
  typedef logic [3:0] res11_t;   // residue modulo 11, 0..10
  typedef logic [1:0] status_t;

  // Verdict codes
  localparam status_t STATUS_VALID     = 2'd0;
  localparam status_t STATUS_BAD_COUNT = 2'd1;
  localparam status_t STATUS_ALL_EQUAL = 2'd2;
  localparam status_t STATUS_MISMATCH  = 2'd3;

  // Digit positions with a special role (zero based)
  localparam count_t IDX_REGION = 4'd8;
  localparam count_t IDX_CHECK1 = 4'd9;
  localparam count_t IDX_CHECK2 = 4'd10;
  localparam count_t IDX_FULL   = 4'd11;

  localparam res11_t RES_ELEVEN = 4'd11;

  // One classified character as it travels from front to back
  typedef struct packed {
    logic   last;
    logic   is_digit;
    digit_t digit;
  } cpf_item_t;

  // Queue occupancy as seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cpf_q_stat_t;

  // (a + b) mod 11 for a < 11 and b < 11
  function automatic res11_t mod11_add(input res11_t a, input res11_t b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, RES_ELEVEN}) begin
      s = s - {1'b0, RES_ELEVEN};
    end
    return s[3:0];
  endfunction

  // ((sum * 10) mod 11) mod 10 given r = sum mod 11; sum*10 is -sum modulo 11
  function automatic digit_t check_of(input res11_t r);
    digit_t c;
    if (r == 4'd0 || r == 4'd1) begin
      c = 4'd0;
    end else begin
      c = RES_ELEVEN - r;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/cpf_in_if.sv -----
// Input character channel: valid/ready handshake carrying one ASCII character.
// Depends on cpf_pkg.
`default_nettype none

interface cpf_in_if;
  logic            valid;
  logic            ready;
  cpf_pkg::char_t  char_code;
  logic            last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ----- src/cpf_out_if.sv -----
// Verdict channel: valid/ready handshake carrying status and region.
// Depends on cpf_pkg.
`default_nettype none

interface cpf_out_if;
  logic             valid;
  logic             ready;
  cpf_pkg::status_t status;
  cpf_pkg::digit_t  region;

  modport source (output valid, output status, output region, input ready);
  modport sink   (input valid, input status, input region, output ready);
endinterface

`default_nettype wire

// ----- src/cpf_front.sv -----
// Front end: accepts characters, classifies digit / non-digit, pushes to the queue.
// Depends on cpf_pkg and cpf_in_if.
`default_nettype none

module cpf_front (
  cpf_in_if.sink                   in_ch,
  input  cpf_pkg::cpf_q_stat_t     q_stat,
  output logic                     push,
  output cpf_pkg::cpf_item_t       push_item
);

  // Take a transaction whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Classify the character
  always_comb begin
    logic [7:0] offs;
    offs                = in_ch.char_code - cpf_pkg::CHAR_ZERO;
    push_item.last      = in_ch.last;
    push_item.is_digit  = (in_ch.char_code >= cpf_pkg::CHAR_ZERO) &&
                          (in_ch.char_code <= cpf_pkg::CHAR_NINE);
    push_item.digit     = offs[3:0];
  end

endmodule

`default_nettype wire

// ----- src/cpf_queue.sv -----
// Short FIFO of classified characters between front and back.
// Depends on cpf_pkg.
`default_nettype none

module cpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  cpf_pkg::cpf_item_t      push_item,
  input  logic                    pop,
  output cpf_pkg::cpf_item_t      head_item,
  output cpf_pkg::cpf_q_stat_t    q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cpf_pkg::cpf_item_t slot_r [DEPTH];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CntFull);
  assign q_stat.empty = (cnt_r == '0);
  assign head_item    = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Occupancy never exceeds the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("queue count out of range");

  // Never written while full, never read while empty
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("queue overrun or underrun");

  // A lone push grows the count by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

`default_nettype wire

// ----- src/cpf_back.sv -----
// Back end: accumulates digit state, forms the verdict on the last character and
// holds it in the output register. Depends on cpf_pkg and cpf_out_if.
`default_nettype none

module cpf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cpf_pkg::cpf_q_stat_t    q_stat,
  input  cpf_pkg::cpf_item_t      head_item,
  output logic                    pop,
  cpf_out_if.source               out_ch
);

  // Accumulation state; sums are kept as residues modulo 11 via prefix sums:
  // p = running digit sum, t = running sum of p; over n digits t + p gives weights n+1..2.
  cpf_pkg::count_t  cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  cpf_pkg::digit_t  first_r, first_nxt;
  logic             all_eq_r, all_eq_nxt;
  cpf_pkg::res11_t  p_r, p_nxt;
  cpf_pkg::res11_t  t_r, t_nxt;
  cpf_pkg::res11_t  res1_r, res1_nxt;
  cpf_pkg::res11_t  res2_r, res2_nxt;
  cpf_pkg::digit_t  region_r, region_nxt;
  cpf_pkg::digit_t  chk1_r, chk1_nxt;
  cpf_pkg::digit_t  chk2_r, chk2_nxt;

  // Output register
  logic             out_valid_r;
  cpf_pkg::status_t out_status_r, out_status_nxt;
  cpf_pkg::digit_t  out_region_r, out_region_nxt;

  logic             take;
  logic             finish;

  // Non-last items always drain; a last item needs a free output slot
  assign pop    = !q_stat.empty &&
                  (!head_item.last || !out_valid_r || out_ch.ready);
  assign take   = pop && head_item.is_digit;
  assign finish = pop && head_item.last;

  // Digit intake
  always_comb begin
    cpf_pkg::res11_t p_new;
    cpf_pkg::res11_t t_new;
    p_new      = cpf_pkg::mod11_add(p_r, head_item.digit);
    t_new      = cpf_pkg::mod11_add(t_r, p_new);
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    first_nxt  = first_r;
    all_eq_nxt = all_eq_r;
    p_nxt      = p_r;
    t_nxt      = t_r;
    res1_nxt   = res1_r;
    res2_nxt   = res2_r;
    region_nxt = region_r;
    chk1_nxt   = chk1_r;
    chk2_nxt   = chk2_r;
    if (take) begin
      if (cnt_r == cpf_pkg::IDX_FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        if (cnt_r == '0) begin
          first_nxt = head_item.digit;
        end else if (head_item.digit != first_r) begin
          all_eq_nxt = 1'b0;
        end
        p_nxt = p_new;
        t_nxt = t_new;
        if (cnt_r == cpf_pkg::IDX_REGION) begin
          res1_nxt   = cpf_pkg::mod11_add(t_new, p_new);
          region_nxt = head_item.digit;
        end
        if (cnt_r == cpf_pkg::IDX_CHECK1) begin
          res2_nxt = cpf_pkg::mod11_add(t_new, p_new);
          chk1_nxt = head_item.digit;
        end
        if (cnt_r == cpf_pkg::IDX_CHECK2) begin
          chk2_nxt = head_item.digit;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Verdict from the state after this item's digit
  always_comb begin
    out_region_nxt = '0;
    priority if (cnt_nxt != cpf_pkg::IDX_FULL || ovf_nxt) begin
      out_status_nxt = cpf_pkg::STATUS_BAD_COUNT;
    end else if (all_eq_nxt) begin
      out_status_nxt = cpf_pkg::STATUS_ALL_EQUAL;
    end else if (cpf_pkg::check_of(res1_nxt) != chk1_nxt ||
                 cpf_pkg::check_of(res2_nxt) != chk2_nxt) begin
      out_status_nxt = cpf_pkg::STATUS_MISMATCH;
    end else begin
      out_status_nxt = cpf_pkg::STATUS_VALID;
      out_region_nxt = region_nxt;
    end
  end

  // State registers; a verdict returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      first_r  <= '0;
      all_eq_r <= 1'b1;
      p_r      <= '0;
      t_r      <= '0;
      res1_r   <= '0;
      res2_r   <= '0;
      region_r <= '0;
      chk1_r   <= '0;
      chk2_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      first_r  <= first_nxt;
      all_eq_r <= all_eq_nxt;
      p_r      <= p_nxt;
      t_r      <= t_nxt;
      res1_r   <= res1_nxt;
      res2_r   <= res2_nxt;
      region_r <= region_nxt;
      chk1_r   <= chk1_nxt;
      chk2_r   <= chk2_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= out_status_nxt;
      out_region_r <= out_region_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.region = out_region_r;

  // The running residues p and t stay below 11 and the count never passes eleven
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_r < cpf_pkg::RES_ELEVEN && t_r < cpf_pkg::RES_ELEVEN &&
    cnt_r <= cpf_pkg::IDX_FULL)
    else $error("accumulator state out of range");

  // A pending verdict is never overwritten
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    !(finish && out_valid_r && !out_ch.ready))
    else $error("verdict overwritten while stalled");

  // A verdict presents a result and restarts the count
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid_r && cnt_r == '0 && !ovf_r && all_eq_r))
    else $error("verdict did not restart the entry");

  // A region is only reported with a valid status
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cpf_pkg::STATUS_VALID) |-> (out_region_r == '0))
    else $error("region reported on an invalid verdict");

endmodule

`default_nettype wire

// ----- src/cpf_check_digit_validator.sv -----
// Top level of the CPF check digit validator: front end, queue and back end.
// Depends on cpf_pkg, cpf_in_if, cpf_out_if, cpf_front, cpf_queue, cpf_back.
//
// Checks a Brazilian CPF number sent as ASCII characters, one per input
// transaction; anything other than '0'..'9' is skipped. The transaction with
// last set closes the entry and produces exactly one verdict transaction:
// status 0 valid (region carries the ninth digit), 1 digit count not eleven,
// 2 all digits equal, 3 check digit mismatch (region is zero unless valid).
// The block takes one character per clock cycle while its queue has room. For
// each entry, the accepting edge writes the last character into the queue;
// the back end then accumulates it and forms the verdict from the queue head,
// and holds the verdict in its output register. A stalled verdict channel
// stops only the next last character, and the input keeps flowing until the
// QUEUE_DEPTH-entry queue fills.
`default_nettype none

module cpf_check_digit_validator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cpf_in_if.sink     in_ch,
  cpf_out_if.source  out_ch
);

  logic                  push;
  logic                  pop;
  cpf_pkg::cpf_item_t    push_item;
  cpf_pkg::cpf_item_t    head_item;
  cpf_pkg::cpf_q_stat_t  q_stat;

  cpf_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  cpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
